/* rtl/core/boot_header_validator_unit_macros.svh */
// ---------------------------------------------------------------------------
// boot_header_validator_unit_macros.svh
// assertion helpers shared by the boot header validator rtl
// ---------------------------------------------------------------------------
`ifndef BOOT_HEADER_VALIDATOR_UNIT_MACROS_SVH
`define BOOT_HEADER_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define BHV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhv assertion failed");

// next-cycle implication, checked on clk while out of reset
`define BHV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhv assertion failed");

`endif

/* rtl/core/bhv_pkg.sv */
// ---------------------------------------------------------------------------
// bhv_pkg
// types and constants of the boot header validator
// ---------------------------------------------------------------------------
package bhv_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned IN_DATA_W  = 320;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  // status codes, first failing check wins
  localparam status_t ST_OK          = 4'd0;
  localparam status_t ST_MAGIC       = 4'd1;
  localparam status_t ST_VERSION     = 4'd2;
  localparam status_t ST_HDR_LEN     = 4'd3;
  localparam status_t ST_TYPE        = 4'd4;
  localparam status_t ST_PAY_ALIGN   = 4'd5;
  localparam status_t ST_SIG_ALIGN   = 4'd6;
  localparam status_t ST_LOAD_ALIGN  = 4'd7;
  localparam status_t ST_ENTRY_ALIGN = 4'd8;
  localparam status_t ST_SIG_LEN     = 4'd9;
  localparam status_t ST_OVERLAP     = 4'd10;
  localparam status_t ST_PAY_BOUNDS  = 4'd11;
  localparam status_t ST_SIG_BOUNDS  = 4'd12;
  localparam status_t ST_LOAD_BOUNDS = 4'd13;
  localparam status_t ST_ENTRY_RANGE = 4'd14;

  // configuration register indexes
  localparam cfg_addr_t REG_EXP_MAGIC   = 4'd0;
  localparam cfg_addr_t REG_EXP_VERSION = 4'd1;
  localparam cfg_addr_t REG_EXP_TYPE    = 4'd2;
  localparam cfg_addr_t REG_IMAGE_BASE  = 4'd3;
  localparam cfg_addr_t REG_DWIN_BASE   = 4'd4;
  localparam cfg_addr_t REG_DWIN_SIZE   = 4'd5;
  localparam cfg_addr_t REG_EWIN_BASE   = 4'd6;
  localparam cfg_addr_t REG_EWIN_SIZE   = 4'd7;

  // register reset values
  localparam word_t RST_IMAGE_BASE = 32'h0002_3000;
  localparam word_t RST_DWIN_BASE  = 32'h0002_0000;
  localparam word_t RST_DWIN_SIZE  = 32'h0001_0000;
  localparam word_t RST_EWIN_BASE  = 32'h0001_0000;
  localparam word_t RST_EWIN_SIZE  = 32'h0001_0000;

  localparam word_t SIG_BYTES  = 32'd64;
  localparam logic [1:0] ALIGN_MASK = 2'b11;

  // operands of one region test
  typedef struct packed {
    word_t addr;
    word_t len;
    word_t base;
    word_t win_end;
  } region_req_t;

endpackage

/* rtl/core/bhv_region_fit.sv */
// ---------------------------------------------------------------------------
// bhv_region_fit
// checks that a nonempty region lies inside a window without 32-bit overflow
// ---------------------------------------------------------------------------
module bhv_region_fit (
  input  bhv_pkg::region_req_t req,
  output logic                 fit
);

  logic [bhv_pkg::WORD_W:0] end_full;

  assign end_full = {1'b0, req.addr} + {1'b0, req.len};

  always_comb begin
    fit = (req.len != '0) && !end_full[bhv_pkg::WORD_W] && (req.addr >= req.base) &&
          (end_full[bhv_pkg::WORD_W-1:0] <= req.win_end);
  end

endmodule

/* rtl/core/boot_header_validator_unit.sv */
// ---------------------------------------------------------------------------
// boot_header_validator_unit
// validates boot image header fields and reports the first failing check
// ---------------------------------------------------------------------------
// One header enters per in_ transfer: in_tdata carries the ten 32-bit header
// fields. One result leaves per out_ transfer: a 4-bit status code (0 when
// every check passes) and the payload source address image_base + offset.
// The cfg_ port writes the expected magic, version and type, the image base
// and the data and execution windows; write it only while no header is in
// flight.
// Pipeline: input register, a stage that forms the sums (payload and
// signature source, load end) and the early checks, then the region
// compares feeding the result register. A header passes through the input
// register, the stage-2 register and the result register before out_tvalid
// rises; one header per cycle is taken while out_tready does not stall.
// A stalled out_tready holds the result register; the stages behind it keep
// taking headers until all three are full, then in_tready drops.
// Reset empties the pipeline and loads the register defaults.
// ---------------------------------------------------------------------------
`include "boot_header_validator_unit_macros.svh"

module boot_header_validator_unit #(
  parameter int unsigned HEADER_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // magic_word, format_version, header_length, image_type, payload_offset,
  // payload_length, signature_offset, signature_length, load_address,
  // entry_address (32 bits each, lowest first)
  input  logic [bhv_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // status [3:0], payload_source [35:4], zero pad [39:36]
  output logic [bhv_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  bhv_pkg::cfg_addr_t               cfg_addr,
  input  bhv_pkg::word_t                   cfg_wdata
);

  // configuration registers
  bhv_pkg::word_t exp_magic_r, exp_version_r, exp_type_r, image_base_r;
  bhv_pkg::word_t dwin_base_r, dwin_size_r, ewin_base_r, ewin_size_r;
  bhv_pkg::word_t dwin_end_r, ewin_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r   <= '0;
      exp_version_r <= '0;
      exp_type_r    <= '0;
      image_base_r  <= bhv_pkg::RST_IMAGE_BASE;
      dwin_base_r   <= bhv_pkg::RST_DWIN_BASE;
      dwin_size_r   <= bhv_pkg::RST_DWIN_SIZE;
      ewin_base_r   <= bhv_pkg::RST_EWIN_BASE;
      ewin_size_r   <= bhv_pkg::RST_EWIN_SIZE;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bhv_pkg::REG_EXP_MAGIC:   exp_magic_r   <= cfg_wdata;
        bhv_pkg::REG_EXP_VERSION: exp_version_r <= cfg_wdata;
        bhv_pkg::REG_EXP_TYPE:    exp_type_r    <= cfg_wdata;
        bhv_pkg::REG_IMAGE_BASE:  image_base_r  <= cfg_wdata;
        bhv_pkg::REG_DWIN_BASE:   dwin_base_r   <= cfg_wdata;
        bhv_pkg::REG_DWIN_SIZE:   dwin_size_r   <= cfg_wdata;
        bhv_pkg::REG_EWIN_BASE:   ewin_base_r   <= cfg_wdata;
        bhv_pkg::REG_EWIN_SIZE:   ewin_size_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window ends wrap to 32 bits
  always_ff @(posedge clk) begin
    dwin_end_r <= dwin_base_r + dwin_size_r;
    ewin_end_r <= ewin_base_r + ewin_size_r;
  end

  // pipeline handshake
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic adv1, adv2, adv3;

  assign adv3      = !s3_vld_r || out_tready;
  assign adv2      = !s2_vld_r || adv3;
  assign adv1      = !s1_vld_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r <= in_tvalid;
      if (adv2) s2_vld_r <= s1_vld_r;
      if (adv3) s3_vld_r <= s2_vld_r;
    end
  end

  // stage 1: input register
  bhv_pkg::word_t s1_magic_r, s1_version_r, s1_hlen_r, s1_type_r, s1_poff_r;
  bhv_pkg::word_t s1_plen_r, s1_soff_r, s1_slen_r, s1_load_r, s1_entry_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_magic_r   <= in_tdata[31:0];
      s1_version_r <= in_tdata[63:32];
      s1_hlen_r    <= in_tdata[95:64];
      s1_type_r    <= in_tdata[127:96];
      s1_poff_r    <= in_tdata[159:128];
      s1_plen_r    <= in_tdata[191:160];
      s1_soff_r    <= in_tdata[223:192];
      s1_slen_r    <= in_tdata[255:224];
      s1_load_r    <= in_tdata[287:256];
      s1_entry_r   <= in_tdata[319:288];
    end
  end

  // stage 2: field checks and address sums
  bhv_pkg::status_t early_nxt, s2_early_r;
  bhv_pkg::word_t   s2_psrc_r, s2_ssrc_r, s2_plen_r, s2_slen_r;
  bhv_pkg::word_t   s2_load_r, s2_load_end_r, s2_entry_r;

  always_comb begin
    priority if (s1_magic_r != exp_magic_r)                  early_nxt = bhv_pkg::ST_MAGIC;
    else if (s1_version_r != exp_version_r)                  early_nxt = bhv_pkg::ST_VERSION;
    else if (s1_hlen_r != bhv_pkg::WORD_W'(HEADER_BYTES))    early_nxt = bhv_pkg::ST_HDR_LEN;
    else if (s1_type_r != exp_type_r)                        early_nxt = bhv_pkg::ST_TYPE;
    else if ((s1_poff_r[1:0] & bhv_pkg::ALIGN_MASK) != '0)   early_nxt = bhv_pkg::ST_PAY_ALIGN;
    else if ((s1_soff_r[1:0] & bhv_pkg::ALIGN_MASK) != '0)   early_nxt = bhv_pkg::ST_SIG_ALIGN;
    else if ((s1_load_r[1:0] & bhv_pkg::ALIGN_MASK) != '0)   early_nxt = bhv_pkg::ST_LOAD_ALIGN;
    else if ((s1_entry_r[1:0] & bhv_pkg::ALIGN_MASK) != '0)  early_nxt = bhv_pkg::ST_ENTRY_ALIGN;
    else if (s1_slen_r != bhv_pkg::SIG_BYTES)                early_nxt = bhv_pkg::ST_SIG_LEN;
    else if (s1_poff_r < s1_hlen_r)                          early_nxt = bhv_pkg::ST_OVERLAP;
    else                                                     early_nxt = bhv_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_early_r    <= early_nxt;
      s2_psrc_r     <= image_base_r + s1_poff_r;
      s2_ssrc_r     <= image_base_r + s1_soff_r;
      s2_plen_r     <= s1_plen_r;
      s2_slen_r     <= s1_slen_r;
      s2_load_r     <= s1_load_r;
      s2_load_end_r <= s1_load_r + s1_plen_r;
      s2_entry_r    <= s1_entry_r;
    end
  end

  // stage 3: region checks into the result register
  bhv_pkg::region_req_t pay_req, sig_req, load_req;
  logic pay_fit, sig_fit, load_fit;
  bhv_pkg::status_t status_nxt, s3_status_r;
  bhv_pkg::word_t   s3_psrc_r;

  assign pay_req  = '{addr: s2_psrc_r, len: s2_plen_r, base: dwin_base_r, win_end: dwin_end_r};
  assign sig_req  = '{addr: s2_ssrc_r, len: s2_slen_r, base: dwin_base_r, win_end: dwin_end_r};
  assign load_req = '{addr: s2_load_r, len: s2_plen_r, base: ewin_base_r, win_end: ewin_end_r};

  bhv_region_fit u_pay_fit  (.req(pay_req),  .fit(pay_fit));
  bhv_region_fit u_sig_fit  (.req(sig_req),  .fit(sig_fit));
  bhv_region_fit u_load_fit (.req(load_req), .fit(load_fit));

  always_comb begin
    priority if (s2_early_r != bhv_pkg::ST_OK) status_nxt = s2_early_r;
    else if (!pay_fit)                          status_nxt = bhv_pkg::ST_PAY_BOUNDS;
    else if (!sig_fit)                          status_nxt = bhv_pkg::ST_SIG_BOUNDS;
    else if (!load_fit)                         status_nxt = bhv_pkg::ST_LOAD_BOUNDS;
    else if ((s2_entry_r < s2_load_r) || (s2_entry_r >= s2_load_end_r))
                                                status_nxt = bhv_pkg::ST_ENTRY_RANGE;
    else                                        status_nxt = bhv_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_status_r <= status_nxt;
      s3_psrc_r   <= s2_psrc_r;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {4'b0000, s3_psrc_r, s3_status_r};

  // a ready sink never backs up the input
  `BHV_ASSERT_NOW(a_ready_chain, out_tready, in_tready)
  // input only blocks when all three stages hold a header
  `BHV_ASSERT_NOW(a_full_stall, !in_tready, s1_vld_r && s2_vld_r && s3_vld_r && !out_tready)
  // a passing header always has its payload at or above the data window base
  `BHV_ASSERT_NOW(a_ok_in_window, out_tvalid && (s3_status_r == bhv_pkg::ST_OK),
                  s3_psrc_r >= dwin_base_r)
  // a stage-2 header moves into the result register when it advances
  `BHV_ASSERT_NEXT(a_stage_move, s2_vld_r && adv3, out_tvalid)

endmodule
